// ===== rtl/rmsd_pkg.sv =====
package rmsd_pkg;

    // Defaults for the top-level parameters.
    localparam int DICT_DEPTH_DEF     = 256;
    localparam int MAX_COUNT_BITS_DEF = 32;

    // Byte queue between the front and the back.
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Fixed field widths.
    localparam int BYTE_W   = 8;
    localparam int FIELD_W  = 32;
    localparam int TAKEN_W  = 6;
    localparam int SYMW_W   = 4;
    localparam int CNTW_W   = 6;
    localparam int DSIZE_W  = 9;
    localparam int EMIT_W   = 33;
    localparam int BITIDX_W = 3;

    // Largest legal symbol width.
    localparam logic [FIELD_W-1:0] MAX_SYM_BITS = 32'd8;

    // Parse phases.
    localparam logic [2:0] PH_SYMW  = 3'd0;
    localparam logic [2:0] PH_CNTW  = 3'd1;
    localparam logic [2:0] PH_DSIZE = 3'd2;
    localparam logic [2:0] PH_RUNS  = 3'd3;
    localparam logic [2:0] PH_MSIZE = 3'd4;
    localparam logic [2:0] PH_DICT  = 3'd5;
    localparam logic [2:0] PH_INDEX = 3'd6;
    localparam logic [2:0] PH_COUNT = 3'd7;

    // One queued input byte.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              start;
    } t_stream_item;

    // One decoded run.
    typedef struct packed {
        logic [BYTE_W-1:0]  symbol;
        logic [FIELD_W-1:0] length;
        logic               last;
        logic               error;
    } t_run;

endpackage

// ===== rtl/rmsd_byte_fifo.sv =====
module rmsd_byte_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  rmsd_pkg::t_stream_item i_item,
    input  logic                  i_pop,
    output logic                  o_full,
    output logic                  o_head_valid,
    output rmsd_pkg::t_stream_item o_head
);
    import rmsd_pkg::*;

    t_stream_item          r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;
    logic [FIFO_PTR_W-1:0] n_wr_ptr;
    logic [FIFO_PTR_W-1:0] n_rd_ptr;
    logic [FIFO_CNT_W-1:0] n_count;

    assign o_full       = (r_count == FIFO_CNT_W'(FIFO_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ===== rtl/rmsd_bit_parser.sv =====
module rmsd_bit_parser #(
    parameter int DICT_DEPTH     = rmsd_pkg::DICT_DEPTH_DEF,
    parameter int MAX_COUNT_BITS = rmsd_pkg::MAX_COUNT_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_head_valid,
    input  rmsd_pkg::t_stream_item i_head,
    input  logic                   i_out_free,
    output logic                   o_pop,
    output logic                   o_emit,
    output rmsd_pkg::t_run         o_run
);
    import rmsd_pkg::*;

    localparam int AW = (DICT_DEPTH > 1) ? $clog2(DICT_DEPTH) : 1;

    logic [BYTE_W-1:0]   r_dict [DICT_DEPTH];
    logic [BYTE_W-1:0]   r_rd_data;

    logic [BITIDX_W-1:0] r_bit_idx;
    logic [2:0]          r_phase;
    logic [TAKEN_W-1:0]  r_taken;
    logic [FIELD_W-1:0]  r_value;
    logic [SYMW_W-1:0]   r_symw;
    logic [CNTW_W-1:0]   r_cntw;
    logic [DSIZE_W-1:0]  r_dleft;
    logic [DSIZE_W-1:0]  r_dsize;
    logic [FIELD_W-1:0]  r_runs;
    logic [BYTE_W-1:0]   r_pidx;
    logic [FIELD_W-1:0]  r_msize;
    logic [EMIT_W-1:0]   r_emitted;

    logic [2:0]          n_phase;
    logic [TAKEN_W-1:0]  n_taken;
    logic [FIELD_W-1:0]  n_value;
    logic [SYMW_W-1:0]   n_symw;
    logic [CNTW_W-1:0]   n_cntw;
    logic [DSIZE_W-1:0]  n_dleft;
    logic [DSIZE_W-1:0]  n_dsize;
    logic [FIELD_W-1:0]  n_runs;
    logic [BYTE_W-1:0]   n_pidx;
    logic [FIELD_W-1:0]  n_msize;
    logic [EMIT_W-1:0]   n_emitted;

    // State as seen by this bit, after an optional stream restart.
    logic [2:0]          c_phase;
    logic [TAKEN_W-1:0]  c_taken;
    logic [FIELD_W-1:0]  c_value;
    logic [SYMW_W-1:0]   c_symw;
    logic [CNTW_W-1:0]   c_cntw;
    logic [DSIZE_W-1:0]  c_dleft;
    logic [DSIZE_W-1:0]  c_dsize;
    logic [FIELD_W-1:0]  c_runs;
    logic [BYTE_W-1:0]   c_pidx;
    logic [FIELD_W-1:0]  c_msize;
    logic [EMIT_W-1:0]   c_emitted;

    logic                step;
    logic                restart;
    logic                cur_bit;
    logic                halted;
    logic [TAKEN_W-1:0]  width;
    logic [TAKEN_W-1:0]  taken_inc;
    logic [FIELD_W-1:0]  val_full;
    logic                done;
    logic                hdr_err;
    logic                dict_wr;
    logic [AW-1:0]       dict_wr_addr;
    logic                idx_rd;
    logic [EMIT_W:0]     sum;
    logic [EMIT_W-1:0]   emit_sat;
    logic [FIELD_W-1:0]  runs_dec;

    assign step    = i_head_valid && i_out_free;
    assign restart = i_head.start && (r_bit_idx == '0);
    assign cur_bit = i_head.data[r_bit_idx];
    assign o_pop   = step && (r_bit_idx == BITIDX_W'(BYTE_W - 1));

    always_comb begin
        c_phase   = restart ? PH_SYMW : r_phase;
        c_taken   = restart ? '0 : r_taken;
        c_value   = restart ? '0 : r_value;
        c_symw    = restart ? '0 : r_symw;
        c_cntw    = restart ? '0 : r_cntw;
        c_dleft   = restart ? '0 : r_dleft;
        c_dsize   = restart ? '0 : r_dsize;
        c_runs    = restart ? '0 : r_runs;
        c_pidx    = restart ? '0 : r_pidx;
        c_msize   = restart ? '0 : r_msize;
        c_emitted = restart ? '0 : r_emitted;
    end

    always_comb begin
        case (c_phase)
            PH_SYMW, PH_CNTW, PH_DICT: width = TAKEN_W'(BYTE_W);
            PH_INDEX:                  width = TAKEN_W'(c_symw);
            PH_COUNT:                  width = c_cntw;
            default:                   width = TAKEN_W'(FIELD_W);
        endcase
    end

    assign halted    = (c_phase == PH_INDEX) && (c_runs == '0);
    assign taken_inc = c_taken + 1'b1;
    assign val_full  = c_value | (FIELD_W'(cur_bit) << c_taken[4:0]);
    assign done      = !halted && (taken_inc >= width);
    assign sum       = {1'b0, c_emitted} + {2'b00, val_full};
    assign emit_sat  = sum[EMIT_W] ? {EMIT_W{1'b1}} : sum[EMIT_W-1:0];
    assign runs_dec  = c_runs - 1'b1;

    always_comb begin
        case (c_phase)
            PH_SYMW:  hdr_err = (val_full == '0) || (val_full > MAX_SYM_BITS);
            PH_CNTW:  hdr_err = (val_full == '0) || (val_full > FIELD_W'(MAX_COUNT_BITS));
            PH_DSIZE: hdr_err = (val_full > FIELD_W'(DICT_DEPTH));
            default:  hdr_err = 1'b0;
        endcase
    end

    always_comb begin
        n_phase   = c_phase;
        n_taken   = c_taken;
        n_value   = c_value;
        n_symw    = c_symw;
        n_cntw    = c_cntw;
        n_dleft   = c_dleft;
        n_dsize   = c_dsize;
        n_runs    = c_runs;
        n_pidx    = c_pidx;
        n_msize   = c_msize;
        n_emitted = c_emitted;
        o_emit    = 1'b0;
        o_run     = '0;
        if (!halted && !done) begin
            n_value = val_full;
            n_taken = taken_inc;
        end else if (done) begin
            n_value = '0;
            n_taken = '0;
            if (hdr_err) begin
                // Header error: one flagged final run, then ignore the stream.
                n_phase     = PH_INDEX;
                n_runs      = '0;
                o_emit      = step;
                o_run.last  = 1'b1;
                o_run.error = 1'b1;
            end else begin
                case (c_phase)
                    PH_SYMW: begin
                        n_symw  = val_full[SYMW_W-1:0];
                        n_phase = PH_CNTW;
                    end
                    PH_CNTW: begin
                        n_cntw  = val_full[CNTW_W-1:0];
                        n_phase = PH_DSIZE;
                    end
                    PH_DSIZE: begin
                        n_dsize = val_full[DSIZE_W-1:0];
                        n_dleft = val_full[DSIZE_W-1:0];
                        n_phase = PH_RUNS;
                    end
                    PH_RUNS: begin
                        n_runs  = val_full;
                        n_phase = PH_MSIZE;
                    end
                    PH_MSIZE: begin
                        n_msize   = val_full;
                        n_emitted = '0;
                        n_phase   = (c_dleft != '0) ? PH_DICT : PH_INDEX;
                    end
                    PH_DICT: begin
                        n_dleft = c_dleft - 1'b1;
                        if (c_dleft == DSIZE_W'(1)) begin
                            n_phase = PH_INDEX;
                        end
                    end
                    PH_INDEX: begin
                        n_pidx  = val_full[BYTE_W-1:0];
                        n_phase = PH_COUNT;
                    end
                    default: begin
                        n_emitted    = emit_sat;
                        n_runs       = runs_dec;
                        n_phase      = PH_INDEX;
                        o_emit       = step;
                        o_run.symbol = ({1'b0, c_pidx} < c_dsize) ? r_rd_data : '0;
                        o_run.length = val_full;
                        o_run.last   = (runs_dec == '0);
                        o_run.error  = (emit_sat > {1'b0, c_msize});
                    end
                endcase
            end
        end
    end

    assign dict_wr      = step && done && !hdr_err && (c_phase == PH_DICT);
    assign dict_wr_addr = AW'(c_dsize - c_dleft);
    assign idx_rd       = step && done && (c_phase == PH_INDEX);

    always_ff @(posedge i_clk) begin
        if (dict_wr) begin
            r_dict[dict_wr_addr] <= val_full[BYTE_W-1:0];
        end
        if (idx_rd) begin
            r_rd_data <= r_dict[val_full[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_idx <= '0;
            r_phase   <= PH_SYMW;
            r_taken   <= '0;
            r_value   <= '0;
            r_symw    <= '0;
            r_cntw    <= '0;
            r_dleft   <= '0;
            r_dsize   <= '0;
            r_runs    <= '0;
            r_pidx    <= '0;
            r_msize   <= '0;
            r_emitted <= '0;
        end else if (step) begin
            r_bit_idx <= r_bit_idx + 1'b1;
            r_phase   <= n_phase;
            r_taken   <= n_taken;
            r_value   <= n_value;
            r_symw    <= n_symw;
            r_cntw    <= n_cntw;
            r_dleft   <= n_dleft;
            r_dsize   <= n_dsize;
            r_runs    <= n_runs;
            r_pidx    <= n_pidx;
            r_msize   <= n_msize;
            r_emitted <= n_emitted;
        end
    end

endmodule

// ===== rtl/rle_mask_stream_decoder_unit.sv =====
// Run-length mask stream decoder.
// The input channel (i_in_valid / o_in_stall) carries one encoded byte per
// transaction, with i_stream_start marking the first byte of a new stream.
// Bits are read least-significant first across bytes: a header, then the
// dictionary, then index/count pairs. The output channel (o_out_valid /
// i_out_stall) carries one decoded run per transaction.
// Accepted bytes enter a two-entry queue. The back end consumes one bit per
// cycle while a byte is queued and the output register is free, and its
// bit-serial field extractor sets the sustained byte rate.
// A run is registered on the cycle its last count bit is read, and
// o_out_valid is driven from that output register.
// When the receiver stalls with a run pending, the bit extractor pauses and
// the queue fills; o_in_stall rises once both queue entries are taken.
// Reset is synchronous and active low. It empties the queue, drops any pending
// run and returns the parser to the symbol width field of the header. The
// dictionary contents are not cleared by reset or by a stream restart.
module rle_mask_stream_decoder_unit #(
    parameter int DICT_DEPTH     = rmsd_pkg::DICT_DEPTH_DEF,
    parameter int MAX_COUNT_BITS = rmsd_pkg::MAX_COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_stream_byte,
    input  logic        i_stream_start,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_run_symbol,
    output logic [31:0] o_run_length,
    output logic        o_last_run,
    output logic        o_format_error
);
    import rmsd_pkg::*;

    t_stream_item in_item;
    t_stream_item head_item;
    logic         fifo_full;
    logic         head_valid;
    logic         push;
    logic         pop;
    logic         out_free;
    logic         run_emit;
    t_run         run_next;

    logic         r_out_valid;
    t_run         r_out_run;

    // The front accepts whenever the queue has room.
    assign in_item.data  = i_stream_byte;
    assign in_item.start = i_stream_start;
    assign o_in_stall    = fifo_full;
    assign push          = i_in_valid && !fifo_full;

    rmsd_byte_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_item       (in_item),
        .i_pop        (pop),
        .o_full       (fifo_full),
        .o_head_valid (head_valid),
        .o_head       (head_item)
    );

    // The back end only advances when the output register can take a run.
    assign out_free = !r_out_valid || !i_out_stall;

    rmsd_bit_parser #(
        .DICT_DEPTH     (DICT_DEPTH),
        .MAX_COUNT_BITS (MAX_COUNT_BITS)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head_item),
        .i_out_free   (out_free),
        .o_pop        (pop),
        .o_emit       (run_emit),
        .o_run        (run_next)
    );

    // Output register: holds a run until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (run_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (run_emit) begin
            r_out_run <= run_next;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_run_symbol   = r_out_run.symbol;
    assign o_run_length   = r_out_run.length;
    assign o_last_run     = r_out_run.last;
    assign o_format_error = r_out_run.error;

`ifndef SYNTHESIS
    // A new run must never overwrite one the receiver has not yet taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        run_emit |-> out_free)
        else $error("run produced while output register is held");

    // The back end only produces runs while it is working on a queued byte.
    a_emit_needs_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        run_emit |-> head_valid)
        else $error("run produced with an empty byte queue");

    // A byte is only dropped from the queue when one is there.
    a_pop_needs_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> head_valid)
        else $error("queue popped while empty");

    // Reset leaves no run pending.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");
`endif

endmodule
